// ----- rtl/card_number_luhn_classifier_core_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the card number checker
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef CARD_NUMBER_LUHN_CLASSIFIER_CORE_ASSERT_SVH
`define CARD_NUMBER_LUHN_CLASSIFIER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CNLC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cnlc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define CNLC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cnlc assertion failed");

`endif

// ----- rtl/cnlc_pkg.sv -----
// ----------------------------------------------------------------------------
// Card number checker package
// Widths, result codes, controller commands and digit helpers.
// ----------------------------------------------------------------------------
package cnlc_pkg;

	localparam int BIN_W       = 63;
	localparam int BCD_DIGITS  = 19;
	localparam int BCD_W       = 4 * BCD_DIGITS;
	localparam int LUHN_DIGITS = 16;
	localparam int CNT_W       = 6;
	localparam int IDX_W       = 5;
	localparam int CLASS_W     = 2;

	localparam logic [CLASS_W-1:0] CLASS_INVALID = 2'd0;
	localparam logic [CLASS_W-1:0] CLASS_PREFIX5 = 2'd1;
	localparam logic [CLASS_W-1:0] CLASS_PREFIX4 = 2'd2;
	localparam logic [CLASS_W-1:0] CLASS_PREFIX3 = 2'd3;

	typedef struct packed {
		logic             load;
		logic             conv_step;
		logic             walk_step;
		logic             out_load;
		logic [IDX_W-1:0] walk_idx;
	} cmd_t;

	// Add-3 correction of one BCD digit ahead of a left shift.
	function automatic logic [3:0] dabble_adj(input logic [3:0] d);
		return (d >= 4'd5) ? 4'(d + 4'd3) : d;
	endfunction

	// Luhn contribution of one digit; odd positions are doubled and folded.
	function automatic logic [3:0] luhn_term(input logic [3:0] d, input logic odd);
		logic [4:0] dbl;
		dbl = {d, 1'b0};
		if (!odd)
			return d;
		return (d >= 4'd5) ? 4'(dbl - 5'd9) : dbl[3:0];
	endfunction

endpackage

// ----- rtl/cnlc_if.sv -----
// ----------------------------------------------------------------------------
// Card number checker channels
// Valid/ready channels for the card number and for the check result.
// ----------------------------------------------------------------------------
interface cnlc_in_if import cnlc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] card_number;

	modport source (output valid, output card_number, input ready);
	modport sink   (input valid, input card_number, output ready);
endinterface

interface cnlc_out_if import cnlc_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] card_class;
	logic               checksum_ok;
	logic [IDX_W-1:0]   digit_count;

	modport source (output valid, output card_class, output checksum_ok,
		output digit_count, input ready);
	modport sink   (input valid, input card_class, input checksum_ok,
		input digit_count, output ready);
endinterface

// ----- rtl/card_number_luhn_classifier_core.sv -----
// A card goes through the bit-serial BCD conversion, then the digit walk, then the hand-off into
// the output register, which waits while the previous result is still held there unread.
// The block takes no new card until the current one has been handed off.
// The output register lets the next card enter while the previous result waits.
// Reset: arst_n is asynchronous, active low, and clears the controller and output valid.
// ----------------------------------------------------------------------------
// Card number Luhn checker and classifier
// Converts a binary card number to decimal, runs the mod-10 check on the
// lowest sixteen digits and classifies it by length and leading digits.
// ----------------------------------------------------------------------------
module card_number_luhn_classifier_core import cnlc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	cnlc_in_if.sink    card_in,
	cnlc_out_if.source result_out
);

	// The controller owns every sequencing decision; the datapath only obeys
	// the command word it receives each cycle.
	cmd_t cmd;

	cnlc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (card_in.valid),
		.in_ready  (card_in.ready),
		.out_valid (result_out.valid),
		.out_ready (result_out.ready),
		.cmd       (cmd)
	);

	// The datapath shifts the card number one bit per cycle into a nineteen
	// digit BCD register, then walks the digits from the lowest up, folding
	// the Luhn sum modulo ten and tracking the highest nonzero digit and the
	// digit below it. The result is captured in output registers when the
	// controller hands it off, so a new transaction can start meanwhile.
	cnlc_datapath u_datapath (
		.clk         (clk),
		.card_number (card_in.card_number),
		.cmd         (cmd),
		.card_class  (result_out.card_class),
		.checksum_ok (result_out.checksum_ok),
		.digit_count (result_out.digit_count)
	);

	`include "card_number_luhn_classifier_core_assert.svh"

	// Once a card is taken, the block is busy and refuses another one.
	`CNLC_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, card_in.valid && card_in.ready, !card_in.ready)

	// A taken result is not shown again unless a fresh one is loaded.
	`CNLC_ASSERT_NEXT(a_no_repeat, clk, arst_n, result_out.valid && result_out.ready && !cmd.out_load, !result_out.valid)

	// A nonzero class is only given to a number that passed the check.
	`CNLC_ASSERT_SAME(a_class_needs_ok, clk, arst_n, result_out.valid && result_out.card_class != CLASS_INVALID, result_out.checksum_ok)

	// The digit count always lies between one and nineteen.
	`CNLC_ASSERT_SAME(a_count_range, clk, arst_n, result_out.valid, result_out.digit_count >= IDX_W'(1) && result_out.digit_count <= IDX_W'(BCD_DIGITS))

endmodule

// ----- rtl/cnlc_ctrl.sv -----
// ----------------------------------------------------------------------------
// Card number checker controller
// Sequences conversion, digit walk and result hand-off.
// ----------------------------------------------------------------------------
module cnlc_ctrl import cnlc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_WALK,
		ST_HOLD
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.conv_step = (state_q == ST_CONV);
		cmd.walk_step = (state_q == ST_WALK);
		cmd.out_load  = (state_q == ST_HOLD) && (!out_valid_q || out_ready);
		cmd.walk_idx  = cnt_q[IDX_W-1:0];
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid)
						state_q <= ST_CONV;
				end
				ST_CONV: begin
					if (cnt_q == CNT_W'(BIN_W - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_WALK;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_WALK: begin
					if (cnt_q == CNT_W'(BCD_DIGITS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_HOLD;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_HOLD: begin
					if (cmd.out_load)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/cnlc_datapath.sv -----
// ----------------------------------------------------------------------------
// Card number checker datapath
// Bit-serial binary to BCD conversion, digit walk and classification.
// ----------------------------------------------------------------------------
module cnlc_datapath import cnlc_pkg::*; (
	input  logic               clk,
	input  logic [BIN_W-1:0]   card_number,
	input  cmd_t               cmd,
	output logic [CLASS_W-1:0] card_class,
	output logic               checksum_ok,
	output logic [IDX_W-1:0]   digit_count
);

	logic [BIN_W-1:0]   bin_q;
	logic [BCD_W-1:0]   bcd_q;
	logic [BCD_W-1:0]   bcd_adj;
	logic [3:0]         sum_q;
	logic [IDX_W-1:0]   count_q;
	logic [3:0]         lead0_q;
	logic [3:0]         lead1_q;
	logic [3:0]         prev_q;
	logic [3:0]         cur_digit;
	logic [4:0]         sum_raw;
	logic [3:0]         sum_next;
	logic               ok;
	logic [CLASS_W-1:0] cls;
	logic [CLASS_W-1:0] card_class_q;
	logic               checksum_ok_q;
	logic [IDX_W-1:0]   digit_count_q;

	always_comb begin
		for (int k = 0; k < BCD_DIGITS; k++)
			bcd_adj[4*k +: 4] = dabble_adj(bcd_q[4*k +: 4]);
	end

	assign cur_digit = bcd_q[3:0];
	assign sum_raw   = {1'b0, sum_q} + {1'b0, luhn_term(cur_digit, cmd.walk_idx[0])};
	assign sum_next  = (sum_raw >= 5'd10) ? 4'(sum_raw - 5'd10) : sum_raw[3:0];

	// Leading-digit rules are tried in priority order and need a passing sum.
	always_comb begin
		ok  = (sum_q == 4'd0);
		cls = CLASS_INVALID;
		if (ok) begin
			if (count_q == IDX_W'(16) && lead0_q == 4'd5 && lead1_q inside {[4'd1:4'd5]})
				cls = CLASS_PREFIX5;
			else if (count_q inside {IDX_W'(13), IDX_W'(16)} && lead0_q == 4'd4)
				cls = CLASS_PREFIX4;
			else if (count_q == IDX_W'(15) && lead0_q == 4'd3 &&
				lead1_q inside {4'd4, 4'd7})
				cls = CLASS_PREFIX3;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q   <= card_number;
			bcd_q   <= '0;
			sum_q   <= '0;
			count_q <= IDX_W'(1);
			lead0_q <= '0;
			lead1_q <= '0;
			prev_q  <= '0;
		end else if (cmd.conv_step) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end else if (cmd.walk_step) begin
			bcd_q  <= {4'd0, bcd_q[BCD_W-1:4]};
			prev_q <= cur_digit;
			if (cmd.walk_idx < IDX_W'(LUHN_DIGITS))
				sum_q <= sum_next;
			if (cur_digit != 4'd0) begin
				count_q <= cmd.walk_idx + IDX_W'(1);
				lead0_q <= cur_digit;
				lead1_q <= prev_q;
			end
		end

		if (cmd.out_load) begin
			card_class_q  <= cls;
			checksum_ok_q <= ok;
			digit_count_q <= count_q;
		end
	end

	assign card_class  = card_class_q;
	assign checksum_ok = checksum_ok_q;
	assign digit_count = digit_count_q;

endmodule
